@@ sv/rrc_pkg.sv @@
package rrc_pkg;

  localparam int RRC_SLOTS = 16;
  localparam int RRC_MAX_USED = 16;

  localparam int CNT_W = 5;
  localparam int SLOT_W = 4;
  localparam int KIND_W = 2;
  localparam int MODE_W = 3;
  localparam int TIME_W = 32;
  localparam int HOUR_W = 5;
  localparam int DAY_W = 3;
  localparam int HMASK_W = 24;
  localparam int DMASK_W = 7;
  localparam int MIN_W = 16;
  localparam int SPAN_W = 22;
  localparam int IN_DATA_W = 112;
  localparam int OUT_DATA_W = 8;

  localparam int SECS_PER_MIN = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int DAYS_PER_WEEK = 7;

  localparam logic [MODE_W-1:0] MODE_PICK = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ZAP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESET_TIMES = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DONE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ALL_DONE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_ATTEMPTED = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SET_POINTER = 3'd7;

  typedef struct packed {
    logic accept;
    logic step;
  } rrc_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic pick_scan;
    logic scan_end;
  } rrc_status_t;

endpackage

@@ sv/rrc_ctrl.sv @@
module rrc_ctrl
  import rrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  rrc_status_t sts,
  output rrc_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !sts.out_busy;
        cmd.accept = s_tvalid && !sts.out_busy;
        if (cmd.accept && sts.pick_scan) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/rrc_datapath.sv @@
module rrc_datapath
  import rrc_pkg::*;
#(
  parameter int SLOTS = RRC_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data,
  input  rrc_cmd_t              cmd,
  output rrc_status_t           sts
);

  // Only the first sixteen slots can ever be addressed or scanned.
  localparam int LIM = (SLOTS < RRC_MAX_USED) ? SLOTS : RRC_MAX_USED;
  localparam int IW = $clog2(LIM);

  logic [LIM-1:0]     entry_valid;
  logic [KIND_W-1:0]  entry_kind [LIM];
  logic [HMASK_W-1:0] entry_hours [LIM];
  logic [DMASK_W-1:0] entry_days [LIM];
  logic [MIN_W-1:0]   entry_redo [LIM];
  logic [MIN_W-1:0]   entry_retry [LIM];
  logic [TIME_W-1:0]  last_success [LIM];
  logic [TIME_W-1:0]  last_attempt [LIM];
  logic [IW-1:0]      scan_pointer;
  logic [CNT_W-1:0]   event_count;

  logic [TIME_W-1:0]  now_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [DAY_W-1:0]   day_r;
  logic [IW-1:0]      idx;
  logic [CNT_W-1:0]   remain;

  logic [SLOT_W-1:0]  out_slot;
  logic [KIND_W-1:0]  out_kind;
  logic               out_found;
  logic               out_status;

  logic [MODE_W-1:0]  mode;
  logic [TIME_W-1:0]  in_now;
  logic [HOUR_W-1:0]  in_hour;
  logic [DAY_W-1:0]   in_day;
  logic [SLOT_W-1:0]  in_slot;
  logic [KIND_W-1:0]  in_kind;
  logic [HMASK_W-1:0] in_hmask;
  logic [DMASK_W-1:0] in_dmask;
  logic [MIN_W-1:0]   in_redo;
  logic [MIN_W-1:0]   in_retry;

  logic [CNT_W-1:0]   cnt;
  logic               in_range;
  logic [IW-1:0]      sidx;
  logic [IW-1:0]      start;
  logic [CNT_W-1:0]   idx_inc;
  logic [IW-1:0]      next_idx;
  logic [SPAN_W-1:0]  redo_secs;
  logic [SPAN_W-1:0]  retry_secs;
  logic [TIME_W-1:0]  since_success;
  logic [TIME_W-1:0]  since_attempt;
  logic               redo_wait;
  logic               retry_wait;
  logic               mask_ok;
  logic               hit;
  logic               last;
  logic               res_write;
  logic               res_found;
  logic [SLOT_W-1:0]  res_slot;
  logic [KIND_W-1:0]  res_kind;
  logic               res_status;

  assign mode     = s_tuser;
  assign in_now   = s_tdata[31:0];
  assign in_hour  = s_tdata[36:32];
  assign in_day   = s_tdata[39:37];
  assign in_slot  = s_tdata[43:40];
  assign in_kind  = s_tdata[45:44];
  assign in_hmask = s_tdata[69:46];
  assign in_dmask = s_tdata[76:70];
  assign in_redo  = s_tdata[92:77];
  assign in_retry = s_tdata[108:93];

  assign cnt = (event_count < CNT_W'(LIM)) ? event_count : CNT_W'(LIM);
  assign in_range = CNT_W'(in_slot) < cnt;
  assign sidx = in_slot[IW-1:0];
  assign start = (CNT_W'(scan_pointer) < cnt) ? scan_pointer : '0;

  assign idx_inc = CNT_W'(idx) + CNT_W'(1);
  assign next_idx = (idx_inc >= cnt) ? '0 : idx_inc[IW-1:0];

  // Whole minutes elapsed stay below the interval exactly when the elapsed
  // seconds stay below the interval in seconds; a future timestamp counts
  // as no time gone by.
  assign redo_secs = SPAN_W'(entry_redo[idx]) * SPAN_W'(SECS_PER_MIN);
  assign retry_secs = SPAN_W'(entry_retry[idx]) * SPAN_W'(SECS_PER_MIN);
  assign since_success = now_r - last_success[idx];
  assign since_attempt = now_r - last_attempt[idx];
  assign redo_wait = (now_r < last_success[idx]) ? (entry_redo[idx] != '0)
                                                 : (since_success < TIME_W'(redo_secs));
  assign retry_wait = (now_r < last_attempt[idx]) ? (entry_retry[idx] != '0)
                                                  : (since_attempt < TIME_W'(retry_secs));
  assign mask_ok = (hour_r < HOUR_W'(HOURS_PER_DAY)) && entry_hours[idx][hour_r] &&
                   (day_r < DAY_W'(DAYS_PER_WEEK)) && entry_days[idx][day_r];
  assign hit = entry_valid[idx] && mask_ok && !redo_wait && !retry_wait;
  assign last = remain == CNT_W'(1);

  assign sts.out_busy = m_tvalid && !m_tready;
  assign sts.pick_scan = (mode == MODE_PICK) && (cnt != '0);
  assign sts.scan_end = hit || last;

  always_comb begin
    res_write = 1'b0;
    res_found = 1'b0;
    res_slot = '0;
    res_kind = '0;
    res_status = 1'b0;
    if (cmd.accept && !sts.pick_scan) begin
      res_write = 1'b1;
      res_status = (mode != MODE_PICK) && (mode != MODE_ALL_DONE) && !in_range;
    end else if (cmd.step && sts.scan_end) begin
      res_write = 1'b1;
      res_found = hit;
      res_slot = hit ? SLOT_W'(idx) : '0;
      res_kind = hit ? entry_kind[idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      scan_pointer <= '0;
      event_count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        event_count <= cfg_data;
      end
      if (res_write) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.accept && in_range) begin
        case (mode)
          MODE_LOAD:        entry_valid[sidx] <= 1'b1;
          MODE_ZAP:         entry_valid[sidx] <= 1'b0;
          MODE_SET_POINTER: scan_pointer <= sidx;
          default: ;
        endcase
      end
      if (cmd.step && hit) begin
        scan_pointer <= next_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && mode == MODE_ALL_DONE) begin
      for (int i = 0; i < LIM; i++) begin
        last_success[i] <= in_now;
        last_attempt[i] <= in_now;
      end
    end
    if (cmd.accept && in_range) begin
      case (mode)
        MODE_LOAD: begin
          entry_kind[sidx] <= in_kind;
          entry_hours[sidx] <= in_hmask;
          entry_days[sidx] <= in_dmask;
          entry_redo[sidx] <= in_redo;
          entry_retry[sidx] <= in_retry;
          last_success[sidx] <= '0;
          last_attempt[sidx] <= '0;
        end
        MODE_RESET_TIMES: begin
          last_success[sidx] <= '0;
          last_attempt[sidx] <= '0;
        end
        MODE_DONE: begin
          last_success[sidx] <= in_now;
          last_attempt[sidx] <= in_now;
        end
        MODE_ATTEMPTED: last_attempt[sidx] <= in_now;
        default: ;
      endcase
    end
    if (cmd.accept && sts.pick_scan) begin
      now_r <= in_now;
      hour_r <= in_hour;
      day_r <= in_day;
      idx <= start;
      remain <= cnt;
    end else if (cmd.step && !sts.scan_end) begin
      idx <= next_idx;
      remain <= remain - CNT_W'(1);
    end
    if (res_write) begin
      out_found <= res_found;
      out_slot <= res_slot;
      out_kind <= res_kind;
      out_status <= res_status;
    end
  end

  assign m_tdata = {1'b0, out_kind, out_slot, out_found};
  assign m_tuser = out_status;
  assign cfg_ready = 1'b1;

endmodule

@@ sv/round_robin_cron_event_picker_unit.sv @@
// Results: a table edit, or a pick on an empty table, gives its result in the cycle after its
// transaction; a pick first scans k entries (1 to the used slot count, at most 16), one per
// cycle through the shared match check, and its result is registered when the scan ends.
// Flow: edits can follow one per cycle while the output is not stalled, and no new item is
// taken during a pick's scan; the next item is taken in the same cycle as the pending result is.
// Reset: the table is marked empty, the scan pointer and event count go to zero.
module round_robin_cron_event_picker_unit
  import rrc_pkg::*;
#(
  parameter int SLOTS = RRC_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // now_seconds, hour_now, weekday_now, slot, event_kind, hour_mask, day_mask,
  // redo_minutes, retry_minutes, zero padding
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // mode
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // found, chosen_slot, chosen_kind, zero padding
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data
);

  rrc_cmd_t    cmd;
  rrc_status_t sts;

  rrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrc_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
